// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks in the RTL. All of them are clocked
// and are switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define WSFCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property in the form "antecedent implies consequent in the same cycle".
`define WSFCS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/wsfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted scale fit package
// Widths, saturation limits, status codes and sequencer states shared by the
// channel interfaces and the fit engine.
// ----------------------------------------------------------------------------
package wsfcs_pkg;

   // Default number of flux bits taken from each input field.
   localparam int FLUX_BITS_DEF = 32;

   // Field widths of the transactions.
   localparam int IN_W     = 32;
   localparam int SCALE_W  = 64;
   localparam int CHI_W    = 63;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 2;

   // Width of the shared multiplier operands.
   localparam int MUL_W = 32;

   // Restoring divider: 64 bits of dividend plus 32 fraction bits.
   localparam int DIV_STEPS = 96;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Symmetric saturation limit of all signed Q32.32 values.
   localparam logic [63:0]        SMAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] SMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_SAT      = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BIN_ESQ,
      ST_BIN_PROD,
      ST_DIV_LOAD,
      ST_DIV,
      ST_DIV_END,
      ST_FIN_START,
      ST_MUL,
      ST_MUL_END,
      ST_CHI,
      ST_FIN_OUT
   } state_type;

endpackage

// ===== rtl/wsfcs_ifs.sv =====
// ----------------------------------------------------------------------------
// Weighted scale fit channels
// Valid/ready channels for the spectral bin input and the fit result.
// ----------------------------------------------------------------------------

// Input channel: one spectral bin per transaction.
interface wsfcs_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [wsfcs_pkg::IN_W-1:0]   measured_flux;
   logic signed [wsfcs_pkg::IN_W-1:0]   model_flux;
   logic        [wsfcs_pkg::IN_W-1:0]   flux_error;
   logic                                bin_masked;
   logic                                last_bin;

   modport source (output valid, measured_flux, model_flux, flux_error, bin_masked,
                   last_bin, input ready);
   modport sink   (input valid, measured_flux, model_flux, flux_error, bin_masked,
                   last_bin, output ready);
endinterface

// Result channel: one fit result per spectrum.
interface wsfcs_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [wsfcs_pkg::SCALE_W-1:0]   fit_scale;
   logic        [wsfcs_pkg::CHI_W-1:0]     chi_square;
   logic        [wsfcs_pkg::COUNT_W-1:0]   bins_used;
   logic        [wsfcs_pkg::STATUS_W-1:0]  fit_status;

   modport source (output valid, fit_scale, chi_square, bins_used, fit_status,
                   input ready);
   modport sink   (input valid, fit_scale, chi_square, bins_used, fit_status,
                   output ready);
endinterface

// ===== rtl/weighted_scale_fit_chi_square.sv =====
// The input is ready only while the sequencer is idle, so a used bin is finished before the
// next bin is taken; an excluded bin that is not last returns straight to idle.
// The last bin runs the final scale, products and chi-square before the result is loaded.
// The work is set by the shared restoring divider, one quotient bit per cycle: three
// divisions per used bin, plus one for the final scale unless the denominator is zero.
// Reset (synchronous, active high) clears the sums, the count, the saturation flag and the output valid.
// ----------------------------------------------------------------------------
// Weighted scale fit with chi-square
// Accumulates 1/err^2 weighted products of measured and model flux per bin and,
// on the last bin, emits the best-fit scale and the one-pass chi-square. One
// 32x32 multiplier, one restoring divider and one saturating adder are shared
// under a small sequencer. The result sits in an output register, so the next
// spectrum starts while it waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module weighted_scale_fit_chi_square #(
   parameter int FLUX_BITS = wsfcs_pkg::FLUX_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   wsfcs_req_if.sink   req_chan,
   wsfcs_rsp_if.source rsp_chan
);

   localparam int MW = wsfcs_pkg::MUL_W;
   localparam int SW = wsfcs_pkg::STEP_W;

   // Sequencer and captured bin.
   wsfcs_pkg::state_type state_ff, state_in;
   logic signed [FLUX_BITS-1:0] meas_ff, meas_in, model_ff, model_in;
   logic [FLUX_BITS-1:0] err_ff, err_in;
   logic last_ff, last_in;

   // Running sums and flags.
   logic signed [63:0] smr_ff, smr_in, srr_ff, srr_in, smm_ff, smm_in;
   logic [wsfcs_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic sat_ff, sat_in;

   // Shared arithmetic registers.
   logic [63:0] prod_ff, prod_in, dsor_ff, dsor_in, dvd_ff, dvd_in;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in;
   logic ovf_ff, ovf_in, neg_ff, neg_in, fin_ff, fin_in;
   logic [SW-1:0] step_ff, step_in;
   logic [1:0] term_ff, term_in, mph_ff, mph_in;
   logic [127:0] wide_ff, wide_in;
   logic signed [63:0] scale_ff, scale_in, p_ff, p_in, ss_ff, ss_in, q_ff, q_in;
   logic signed [63:0] chi_ff, chi_in;

   // Output register.
   logic out_valid_ff, out_valid_in;
   logic signed [wsfcs_pkg::SCALE_W-1:0] out_scale_ff, out_scale_in;
   logic [wsfcs_pkg::CHI_W-1:0] out_chi_ff, out_chi_in;
   logic [wsfcs_pkg::COUNT_W-1:0] out_bins_ff, out_bins_in;
   wsfcs_pkg::status_type out_status_ff, out_status_in;

   // Combinational helpers.
   logic req_fire, rsp_fire, req_use;
   logic signed [32:0] meas_sx, model_sx, meas_abs, model_abs;
   logic [MW-1:0] meas_mag, model_mag, mul_a, mul_b;
   logic [2*MW-1:0] mul_p;
   logic signed [63:0] opx, opy;
   logic [63:0] xm, ym;
   logic div_bit, div_carry, div_ge;
   logic [63:0] div_rs, div_diff;
   logic qsat, msat;
   logic [63:0] qmag, mmag;
   logic signed [63:0] qval, mval;
   logic signed [63:0] sa_a, sa_b, sa_res;
   logic signed [64:0] sa_sum;
   logic sa_sat;
   logic [127:0] wide_add;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign req_use  = !req_chan.bin_masked && (req_chan.flux_error[FLUX_BITS-1:0] != '0);

   assign req_chan.ready        = (state_ff == wsfcs_pkg::ST_IDLE);
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.fit_scale    = out_scale_ff;
   assign rsp_chan.chi_square   = out_chi_ff;
   assign rsp_chan.bins_used    = out_bins_ff;
   assign rsp_chan.fit_status   = out_status_ff;

   // Flux magnitudes for the per-bin products.
   assign meas_sx   = 33'(meas_ff);
   assign model_sx  = 33'(model_ff);
   assign meas_abs  = meas_sx[32] ? -meas_sx : meas_sx;
   assign model_abs = model_sx[32] ? -model_sx : model_sx;
   assign meas_mag  = meas_abs[MW-1:0];
   assign model_mag = model_abs[MW-1:0];

   // Shared multiplier.
   assign mul_p = mul_a * mul_b;

   // Operands of the Q32.32 products in the final phase.
   always_comb begin
      case (term_ff)
         2'd0: begin
            opx = scale_ff;
            opy = smr_ff;
         end
         2'd1: begin
            opx = scale_ff;
            opy = scale_ff;
         end
         default: begin
            opx = ss_ff;
            opy = srr_ff;
         end
      endcase
   end
   assign xm = opx[63] ? 64'(-opx) : 64'(opx);
   assign ym = opy[63] ? 64'(-opy) : 64'(opy);

   // One restoring divider step.
   assign div_bit   = dvd_ff[63];
   assign div_carry = rem_ff[63];
   assign div_rs    = {rem_ff[62:0], div_bit};
   assign div_ge    = div_carry || (div_rs >= dsor_ff);
   assign div_diff  = div_rs - dsor_ff;

   // Saturated quotient and product with their signs applied.
   assign qsat = ovf_ff || quo_ff[63];
   assign qmag = qsat ? wsfcs_pkg::SMAX : quo_ff;
   assign qval = neg_ff ? -$signed(qmag) : $signed(qmag);
   assign msat = (wide_ff[127:95] != '0);
   assign mmag = msat ? wsfcs_pkg::SMAX : wide_ff[95:32];
   assign mval = neg_ff ? -$signed(mmag) : $signed(mmag);

   // Shared saturating adder.
   assign sa_sum = $signed({sa_a[63], sa_a}) + $signed({sa_b[63], sa_b});
   always_comb begin
      sa_sat = 1'b0;
      sa_res = sa_sum[63:0];
      if (sa_sum > wsfcs_pkg::SMAX65) begin
         sa_sat = 1'b1;
         sa_res = $signed(wsfcs_pkg::SMAX);
      end else if (sa_sum < -wsfcs_pkg::SMAX65) begin
         sa_sat = 1'b1;
         sa_res = -$signed(wsfcs_pkg::SMAX);
      end
   end

   // Partial product placed at its weight for the 64x64 product.
   always_comb begin
      case (mph_ff)
         2'b00:   wide_add = 128'(prod_ff);
         2'b11:   wide_add = 128'(prod_ff) << 64;
         default: wide_add = 128'(prod_ff) << 32;
      endcase
   end

   // Next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      meas_in       = meas_ff;
      model_in      = model_ff;
      err_in        = err_ff;
      last_in       = last_ff;
      smr_in        = smr_ff;
      srr_in        = srr_ff;
      smm_in        = smm_ff;
      cnt_in        = cnt_ff;
      sat_in        = sat_ff;
      prod_in       = prod_ff;
      dsor_in       = dsor_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      ovf_in        = ovf_ff;
      neg_in        = neg_ff;
      fin_in        = fin_ff;
      step_in       = step_ff;
      term_in       = term_ff;
      mph_in        = mph_ff;
      wide_in       = wide_ff;
      scale_in      = scale_ff;
      p_in          = p_ff;
      ss_in         = ss_ff;
      q_in          = q_ff;
      chi_in        = chi_ff;
      out_valid_in  = out_valid_ff && !rsp_fire;
      out_scale_in  = out_scale_ff;
      out_chi_in    = out_chi_ff;
      out_bins_in   = out_bins_ff;
      out_status_in = out_status_ff;
      mul_a         = '0;
      mul_b         = '0;
      sa_a          = '0;
      sa_b          = '0;

      case (state_ff)
         wsfcs_pkg::ST_IDLE: begin
            if (req_fire) begin
               meas_in  = req_chan.measured_flux[FLUX_BITS-1:0];
               model_in = req_chan.model_flux[FLUX_BITS-1:0];
               err_in   = req_chan.flux_error[FLUX_BITS-1:0];
               last_in  = req_chan.last_bin;
               if (req_use) begin
                  state_in = wsfcs_pkg::ST_BIN_ESQ;
               end else if (req_chan.last_bin) begin
                  state_in = wsfcs_pkg::ST_FIN_START;
               end
            end
         end

         // Error squared, the divisor of all three bin terms.
         wsfcs_pkg::ST_BIN_ESQ: begin
            mul_a    = MW'(err_ff);
            mul_b    = MW'(err_ff);
            prod_in  = mul_p;
            term_in  = 2'd0;
            state_in = wsfcs_pkg::ST_BIN_PROD;
         end

         // Flux product of the current term.
         wsfcs_pkg::ST_BIN_PROD: begin
            case (term_ff)
               2'd0: begin
                  mul_a  = meas_mag;
                  mul_b  = model_mag;
                  neg_in = meas_ff[FLUX_BITS-1] ^ model_ff[FLUX_BITS-1];
               end
               2'd1: begin
                  mul_a  = model_mag;
                  mul_b  = model_mag;
                  neg_in = 1'b0;
               end
               default: begin
                  mul_a  = meas_mag;
                  mul_b  = meas_mag;
                  neg_in = 1'b0;
               end
            endcase
            if (term_ff == 2'd0) begin
               dsor_in = prod_ff;
            end
            prod_in  = mul_p;
            fin_in   = 1'b0;
            state_in = wsfcs_pkg::ST_DIV_LOAD;
         end

         wsfcs_pkg::ST_DIV_LOAD: begin
            dvd_in   = prod_ff;
            rem_in   = '0;
            quo_in   = '0;
            ovf_in   = 1'b0;
            step_in  = SW'(wsfcs_pkg::DIV_STEPS - 1);
            state_in = wsfcs_pkg::ST_DIV;
         end

         // One quotient bit per cycle.
         wsfcs_pkg::ST_DIV: begin
            rem_in  = div_ge ? div_diff : div_rs;
            quo_in  = {quo_ff[62:0], div_ge};
            ovf_in  = ovf_ff || quo_ff[63];
            dvd_in  = {dvd_ff[62:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = wsfcs_pkg::ST_DIV_END;
            end
         end

         wsfcs_pkg::ST_DIV_END: begin
            if (fin_ff) begin
               scale_in = qval;
               sat_in   = sat_ff || qsat;
               term_in  = 2'd0;
               step_in  = '0;
               state_in = wsfcs_pkg::ST_MUL;
            end else begin
               // Add the weighted term into its sum.
               case (term_ff)
                  2'd0:    sa_a = smr_ff;
                  2'd1:    sa_a = srr_ff;
                  default: sa_a = smm_ff;
               endcase
               sa_b = qval;
               case (term_ff)
                  2'd0:    smr_in = sa_res;
                  2'd1:    srr_in = sa_res;
                  default: smm_in = sa_res;
               endcase
               sat_in = sat_ff || qsat || sa_sat;
               if (term_ff == 2'd2) begin
                  if (cnt_ff == '1) begin
                     sat_in = 1'b1;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
                  state_in = last_ff ? wsfcs_pkg::ST_FIN_START : wsfcs_pkg::ST_IDLE;
               end else begin
                  term_in  = term_ff + 1'b1;
                  state_in = wsfcs_pkg::ST_BIN_PROD;
               end
            end
         end

         // Scale division, or a zero scale when the denominator is zero.
         wsfcs_pkg::ST_FIN_START: begin
            chi_in  = smm_ff;
            term_in = 2'd0;
            if (srr_ff == '0) begin
               scale_in = '0;
               step_in  = '0;
               state_in = wsfcs_pkg::ST_MUL;
            end else begin
               dvd_in   = smr_ff[63] ? 64'(-smr_ff) : 64'(smr_ff);
               dsor_in  = srr_ff[63] ? 64'(-srr_ff) : 64'(srr_ff);
               rem_in   = '0;
               quo_in   = '0;
               ovf_in   = 1'b0;
               neg_in   = smr_ff[63] ^ srr_ff[63];
               fin_in   = 1'b1;
               step_in  = SW'(wsfcs_pkg::DIV_STEPS - 1);
               state_in = wsfcs_pkg::ST_DIV;
            end
         end

         // 64x64 magnitude product from four 32x32 partial products.
         wsfcs_pkg::ST_MUL: begin
            neg_in = opx[63] ^ opy[63];
            if (step_ff < SW'(4)) begin
               mul_a   = step_ff[1] ? xm[63:32] : xm[31:0];
               mul_b   = step_ff[0] ? ym[63:32] : ym[31:0];
               prod_in = mul_p;
               mph_in  = step_ff[1:0];
            end
            if (step_ff == '0) begin
               wide_in = '0;
            end else begin
               wide_in = wide_ff + wide_add;
            end
            if (step_ff == SW'(4)) begin
               state_in = wsfcs_pkg::ST_MUL_END;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         wsfcs_pkg::ST_MUL_END: begin
            sat_in  = sat_ff || msat;
            step_in = '0;
            case (term_ff)
               2'd0:    p_in  = mval;
               2'd1:    ss_in = mval;
               default: q_in  = mval;
            endcase
            if (term_ff == 2'd2) begin
               state_in = wsfcs_pkg::ST_CHI;
            end else begin
               term_in  = term_ff + 1'b1;
               state_in = wsfcs_pkg::ST_MUL;
            end
         end

         // Chi accumulation: subtract p twice, then add q.
         wsfcs_pkg::ST_CHI: begin
            sa_a   = chi_ff;
            sa_b   = (step_ff == SW'(2)) ? q_ff : -p_ff;
            chi_in = sa_res;
            sat_in = sat_ff || sa_sat;
            if (step_ff == SW'(2)) begin
               state_in = wsfcs_pkg::ST_FIN_OUT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         // Load the result once the output register is free, then clear the sums.
         wsfcs_pkg::ST_FIN_OUT: begin
            if (!out_valid_ff || rsp_fire) begin
               out_valid_in = 1'b1;
               out_scale_in = scale_ff;
               out_chi_in   = chi_ff[63] ? '0 : chi_ff[63:1];
               out_bins_in  = cnt_ff;
               if (srr_ff == '0) begin
                  out_status_in = wsfcs_pkg::STATUS_ZERO_DEN;
               end else if (sat_ff) begin
                  out_status_in = wsfcs_pkg::STATUS_SAT;
               end else begin
                  out_status_in = wsfcs_pkg::STATUS_OK;
               end
               smr_in   = '0;
               srr_in   = '0;
               smm_in   = '0;
               cnt_in   = '0;
               sat_in   = 1'b0;
               state_in = wsfcs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wsfcs_pkg::ST_IDLE;
         end
      endcase
   end

   // State register and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsfcs_pkg::ST_IDLE;
         smr_ff       <= '0;
         srr_ff       <= '0;
         smm_ff       <= '0;
         cnt_ff       <= '0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         smr_ff       <= smr_in;
         srr_ff       <= srr_in;
         smm_ff       <= smm_in;
         cnt_ff       <= cnt_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload and arithmetic registers.
   always_ff @(posedge clock) begin
      meas_ff       <= meas_in;
      model_ff      <= model_in;
      err_ff        <= err_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      dsor_ff       <= dsor_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      ovf_ff        <= ovf_in;
      neg_ff        <= neg_in;
      fin_ff        <= fin_in;
      step_ff       <= step_in;
      term_ff       <= term_in;
      mph_ff        <= mph_in;
      wide_ff       <= wide_in;
      scale_ff      <= scale_in;
      p_ff          <= p_in;
      ss_ff         <= ss_in;
      q_ff          <= q_in;
      chi_ff        <= chi_in;
      out_scale_ff  <= out_scale_in;
      out_chi_ff    <= out_chi_in;
      out_bins_ff   <= out_bins_in;
      out_status_ff <= out_status_in;
   end

   // A zero denominator always comes with a zero scale.
   `WSFCS_ASSERT_IMPLY(a_zero_den_scale, clock, reset, rsp_chan.valid && (out_status_ff == wsfcs_pkg::STATUS_ZERO_DEN), rsp_chan.fit_scale == '0, "zero denominator with nonzero scale")

   // An excluded bin that is not last leaves the block ready in the next cycle.
   `WSFCS_ASSERT(a_skip_bin, clock, reset, (req_fire && !req_use && !req_chan.last_bin) |=> (state_ff == wsfcs_pkg::ST_IDLE), "excluded bin did not return to idle")

   // The reported status is one of the defined codes.
   `WSFCS_ASSERT_IMPLY(a_status_code, clock, reset, rsp_chan.valid, (out_status_ff == wsfcs_pkg::STATUS_OK) || (out_status_ff == wsfcs_pkg::STATUS_ZERO_DEN) || (out_status_ff == wsfcs_pkg::STATUS_SAT), "undefined fit status")

endmodule

// ===== tb/sv/weighted_scale_fit_chi_square_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted scale fit testbench
// Feeds spectra of bins through the valid/ready input channel and checks each
// fit result against an in-bench predictor of the saturating sums, the scale
// divide and the one-pass chi-square. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module weighted_scale_fit_chi_square_tb;

   localparam int NUM_RANDOM   = 2000;
   localparam int CALM_ITEMS   = 150;
   localparam int LONG_HOLD    = 1500;
   localparam int SETTLE       = 450;
   localparam int STALL_LIMIT  = 10000;

   typedef struct {
      logic signed [31:0] meas;
      logic signed [31:0] model;
      logic [31:0]        err;
      logic               masked;
      logic               last;
   } bin_type;

   typedef struct {
      logic signed [wsfcs_pkg::SCALE_W-1:0] scale;
      logic [wsfcs_pkg::CHI_W-1:0]          chi;
      logic [wsfcs_pkg::COUNT_W-1:0]        used;
      logic [wsfcs_pkg::STATUS_W-1:0]       status;
   } fit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsfcs_req_if req_bus ();
   wsfcs_rsp_if rsp_bus ();

   weighted_scale_fit_chi_square uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   bin_type bin_q[$];
   fit_type fit_expect_q[$];
   int   mismatches = 0;
   int   bins_accepted = 0;
   int   send_gap = 0;
   int   recv_gap = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   int   idle_cycles = 0;

   // Predictor state for the spectrum being accumulated.
   logic signed [63:0] acc_mr, acc_rr, acc_mm;
   logic [15:0]        acc_count;
   bit                 acc_sat;

   // Clock generation.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Inputs start at known values before the first edge.
   initial begin
      req_bus.valid = 1'b0;
      req_bus.measured_flux = '0;
      req_bus.model_flux = '0;
      req_bus.flux_error = '0;
      req_bus.bin_masked = 1'b0;
      req_bus.last_bin = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   function automatic logic [63:0] magnitude(input logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   // Saturating signed add, symmetric at +-SMAX.
   function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  inout bit sat);
      logic signed [64:0] t;
      t = $signed({a[63], a}) + $signed({b[63], b});
      if (t > wsfcs_pkg::SMAX65) begin
         sat = 1'b1;
         return wsfcs_pkg::SMAX;
      end
      if (t < -wsfcs_pkg::SMAX65) begin
         sat = 1'b1;
         return -$signed(wsfcs_pkg::SMAX);
      end
      return t[63:0];
   endfunction

   // floor(mag * 2^32 / d), capped at SMAX.
   function automatic logic [63:0] q32_quotient(input logic [63:0] mag, input logic [63:0] d,
                                                inout bit sat);
      logic [127:0] q;
      q = {32'b0, mag, 32'b0} / {64'b0, d};
      if (q > {64'b0, wsfcs_pkg::SMAX}) begin
         sat = 1'b1;
         return wsfcs_pkg::SMAX;
      end
      return q[63:0];
   endfunction

   // Signed Q32.32 product, truncated toward zero and saturated.
   function automatic logic signed [63:0] q32_product(input logic signed [63:0] x,
                                                      input logic signed [63:0] y,
                                                      inout bit sat);
      logic [127:0] p;
      logic [63:0]  m;
      p = {64'b0, magnitude(x)} * {64'b0, magnitude(y)};
      p = p >> 32;
      if (p > {64'b0, wsfcs_pkg::SMAX}) begin
         sat = 1'b1;
         m = wsfcs_pkg::SMAX;
      end else begin
         m = p[63:0];
      end
      return (x[63] != y[63]) ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] weighted_term(input logic signed [31:0] x,
                                                        input logic signed [31:0] y,
                                                        input logic [63:0] esq,
                                                        inout bit sat);
      logic [63:0] m;
      logic [63:0] q;
      m = magnitude(64'(x)) * magnitude(64'(y));
      q = q32_quotient(m, esq, sat);
      return (x[31] != y[31]) ? -$signed(q) : $signed(q);
   endfunction

   task automatic clear_sums();
      acc_mr = '0;
      acc_rr = '0;
      acc_mm = '0;
      acc_count = '0;
      acc_sat = 1'b0;
   endtask

   // Fold one accepted bin into the sums; on the last bin queue the expected fit.
   task automatic fold_bin(input bin_type b);
      logic [63:0]        esq;
      logic signed [63:0] s, p, q, acc;
      fit_type            f;
      bit                 sat;
      sat = acc_sat;
      if (!b.masked && b.err != 0) begin
         esq = 64'(b.err) * 64'(b.err);
         acc_mr = sat_sum(acc_mr, weighted_term(b.meas, b.model, esq, sat), sat);
         acc_rr = sat_sum(acc_rr, weighted_term(b.model, b.model, esq, sat), sat);
         acc_mm = sat_sum(acc_mm, weighted_term(b.meas, b.meas, esq, sat), sat);
         if (acc_count == 16'hFFFF) sat = 1'b1;
         else acc_count = acc_count + 1'b1;
      end
      acc_sat = sat;
      if (!b.last) return;
      s = '0;
      if (acc_rr != 0) begin
         q = q32_quotient(magnitude(acc_mr), magnitude(acc_rr), sat);
         s = (acc_mr[63] != acc_rr[63]) ? -q : q;
      end
      p = q32_product(s, acc_mr, sat);
      q = q32_product(q32_product(s, s, sat), acc_rr, sat);
      acc = acc_mm;
      acc = sat_sum(acc, -p, sat);
      acc = sat_sum(acc, -p, sat);
      acc = sat_sum(acc, q, sat);
      if (acc < 0) acc = '0;
      f.scale = s;
      f.chi = acc[63:1];
      f.used = acc_count;
      if (acc_rr == 0) f.status = wsfcs_pkg::STATUS_ZERO_DEN;
      else if (sat) f.status = wsfcs_pkg::STATUS_SAT;
      else f.status = wsfcs_pkg::STATUS_OK;
      fit_expect_q.insert(fit_expect_q.size(), f);
      clear_sums();
   endtask

   // Flux values drawn from a mix of full-range, small and extreme classes.
   function automatic logic [31:0] pick_flux();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return 32'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
         3: case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return 32'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
      endcase
   endfunction

   function automatic logic [31:0] pick_error();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: return $urandom_range(1, 255);
         3: return 32'd0;
         4: return ($urandom_range(0, 1) != 0) ? 32'd1 : 32'hFFFF_FFFF;
         default: return $urandom_range(32'h1000, 32'h100000);
      endcase
   endfunction

   task automatic add_bin(input logic [31:0] m, input logic [31:0] r, input logic [31:0] e,
                          input logic masked, input logic last);
      bin_type b;
      b.meas = m;
      b.model = r;
      b.err = e;
      b.masked = masked;
      b.last = last;
      bin_q.insert(bin_q.size(), b);
   endtask

   task automatic wait_drained();
      wait (bin_q.size() == 0 && !req_bus.valid);
      wait (fit_expect_q.size() == 0);
   endtask

   // Input driver: offers queued bins with random gaps except near the end.
   always @(posedge clock) begin
      bin_type nb;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (bin_q.size() > 0) begin
            nb = bin_q.pop_front();
            req_bus.measured_flux <= nb.meas;
            req_bus.model_flux <= nb.model;
            req_bus.flux_error <= nb.err;
            req_bus.bin_masked <= nb.masked;
            req_bus.last_bin <= nb.last;
            req_bus.valid <= 1'b1;
            if (bin_q.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 3);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result ready: one long hold-off mid run, short random stalls otherwise.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && bins_accepted >= 600) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= (hold_left == 0);
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_bus.ready <= (recv_gap == 0);
      end else if (bin_q.size() >= CALM_ITEMS && $urandom_range(0, 5) == 0) begin
         recv_gap = $urandom_range(1, 3);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Monitor: predicts on accepted bins and checks accepted fit results.
   always @(posedge clock) begin
      bin_type b;
      fit_type f;
      if (reset) begin
         clear_sums();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            b.meas = req_bus.measured_flux;
            b.model = req_bus.model_flux;
            b.err = req_bus.flux_error;
            b.masked = req_bus.bin_masked;
            b.last = req_bus.last_bin;
            fold_bin(b);
            bins_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (fit_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected fit result scale=%h chi=%h used=%0d status=%0d",
                           rsp_bus.fit_scale, rsp_bus.chi_square, rsp_bus.bins_used,
                           rsp_bus.fit_status);
            end else begin
               f = fit_expect_q.pop_front();
               if (rsp_bus.fit_scale !== f.scale || rsp_bus.chi_square !== f.chi ||
                   rsp_bus.bins_used !== f.used || rsp_bus.fit_status !== f.status) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: fit mismatch at %0t", $realtime);
                     $display("  expected scale=%h chi=%h used=%0d status=%0d",
                              f.scale, f.chi, f.used, f.status);
                     $display("  actual   scale=%h chi=%h used=%0d status=%0d",
                              rsp_bus.fit_scale, rsp_bus.chi_square, rsp_bus.bins_used,
                              rsp_bus.fit_status);
                  end
               end
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("weighted_scale_fit_chi_square_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed spectra, then random spectra in two halves.
   initial begin
      int n;
      int total;
      bit paused;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Nothing used: masked bin alone, then a zero-error bin alone.
      add_bin(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1);
      add_bin(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b0, 1'b1);
      // Plain unit fit and a negative scale.
      add_bin(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b1);
      add_bin(32'hFFFE_0000, 32'h0001_0000, 32'h0000_8000, 1'b0, 1'b0);
      add_bin(32'h0003_0000, 32'hFFFF_0000, 32'h0002_0000, 1'b0, 1'b1);
      // Extreme fields with the largest error.
      add_bin(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
      add_bin(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
      // Smallest error with full-scale flux saturates the sums.
      add_bin(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0);
      add_bin(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b1);
      // Zero model flux gives a zero denominator with a nonzero meas sum.
      add_bin(32'h0005_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 1'b0);
      add_bin(32'hFFF0_0000, 32'h0000_0000, 32'h0000_0100, 1'b0, 1'b1);
      // Mixed spectrum with excluded bins in the middle.
      add_bin(32'h0002_0000, 32'h0001_8000, 32'h0000_4000, 1'b0, 1'b0);
      add_bin(32'h1234_5678, 32'h0FED_CBA9, 32'h0000_0000, 1'b0, 1'b0);
      add_bin(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h0001_0000, 1'b1, 1'b0);
      add_bin(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0);
      add_bin(32'h0004_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, 1'b1);
      // Masked last bin after used bins.
      add_bin(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 1'b0, 1'b0);
      add_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1);
      wait_drained();

      // Random spectra of one to six bins; every so often a stray excluded bin.
      total = 0;
      paused = 1'b0;
      while (total < NUM_RANDOM) begin
         if (!paused && total >= NUM_RANDOM / 2) begin
            paused = 1'b1;
            wait_drained();
         end
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            add_bin(pick_flux(), pick_flux(), pick_error(),
                    ($urandom_range(0, 9) == 0), (i == n - 1));
            total++;
            if (total == NUM_RANDOM / 2 && i != n - 1) begin
               // Finish the spectrum so the pause falls between spectra.
               add_bin(pick_flux(), pick_flux(), pick_error(), 1'b0, 1'b1);
               total++;
               break;
            end
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && fit_expect_q.size() == 0)
         $display("weighted_scale_fit_chi_square_tb: PASS");
      else
         $display("weighted_scale_fit_chi_square_tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wsfcs_pkg.sv
rtl/wsfcs_ifs.sv
rtl/weighted_scale_fit_chi_square.sv
tb/sv/weighted_scale_fit_chi_square_tb.sv
